### rtl/tspw_pkg.sv
// ----------------------------------------------------------------------------
// Two-stage page walk: shared package
// Types, codes, constants and the microcode store of the walk sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tspw_pkg;

  // Default number of 512-word table pages held in the table memory.
  localparam int unsigned MEM_PAGES_DEFAULT = 64;

  // Table layout.
  localparam int unsigned IDX_BITS   = 9;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PPN_LSB    = 10;
  localparam int unsigned PPN_BITS   = 44;
  localparam int unsigned ENTRY_BITS = 64;
  localparam int unsigned ADDR_BITS  = 56;
  localparam int unsigned GVA_BITS   = 30;
  localparam int unsigned WIDX_BITS  = 15;
  localparam int unsigned ROOT_BITS  = 6;

  // Entry flag positions.
  localparam int unsigned FLAG_V = 0;
  localparam int unsigned FLAG_R = 1;
  localparam int unsigned FLAG_W = 2;
  localparam int unsigned FLAG_X = 3;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_S1_FAULT  = 2'd1;
  localparam status_t ST_S2_FAULT  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_STAGE1_ROOT = 1'b0;
  localparam logic REG_STAGE2_ROOT = 1'b1;

  // Datapath operations, one per microcode step.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_WRITE,
    OP_ROOT,
    OP_PTR,
    OP_LEAF,
    OP_DONE,
    OP_FAULT,
    OP_CLEAR
  } op_t;

  // Branch outcome reported by the datapath to the sequencer.
  typedef enum logic [1:0] {
    BR_SEQ,
    BR_A,
    BR_B
  } br_t;

  // Step addresses of the microprogram.
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_WRITE = 3'd1;
  localparam step_t STEP_ROOT  = 3'd2;
  localparam step_t STEP_PTR   = 3'd3;
  localparam step_t STEP_LEAF  = 3'd4;
  localparam step_t STEP_DONE  = 3'd5;
  localparam step_t STEP_FAULT = 3'd6;
  localparam step_t STEP_CLEAR = 3'd7;

  // One control word: operation, ready flag and the three successor steps.
  typedef struct packed {
    logic  ready;
    op_t   op;
    step_t seq;
    step_t jmp_a;
    step_t jmp_b;
  } ctrl_t;

  // Microcode store. Branch A is the exceptional exit of a step (fault,
  // write dispatch, clear loop); branch B restarts the walk for stage 2 or
  // dispatches a translation.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    unique case (s)
      STEP_IDLE:  w = '{ready: 1'b1, op: OP_IDLE,  seq: STEP_IDLE,
                        jmp_a: STEP_WRITE, jmp_b: STEP_ROOT};
      STEP_WRITE: w = '{ready: 1'b0, op: OP_WRITE, seq: STEP_IDLE,
                        jmp_a: STEP_IDLE,  jmp_b: STEP_IDLE};
      STEP_ROOT:  w = '{ready: 1'b0, op: OP_ROOT,  seq: STEP_PTR,
                        jmp_a: STEP_FAULT, jmp_b: STEP_FAULT};
      STEP_PTR:   w = '{ready: 1'b0, op: OP_PTR,   seq: STEP_LEAF,
                        jmp_a: STEP_FAULT, jmp_b: STEP_FAULT};
      STEP_LEAF:  w = '{ready: 1'b0, op: OP_LEAF,  seq: STEP_DONE,
                        jmp_a: STEP_FAULT, jmp_b: STEP_ROOT};
      STEP_DONE:  w = '{ready: 1'b0, op: OP_DONE,  seq: STEP_IDLE,
                        jmp_a: STEP_IDLE,  jmp_b: STEP_IDLE};
      STEP_FAULT: w = '{ready: 1'b0, op: OP_FAULT, seq: STEP_IDLE,
                        jmp_a: STEP_IDLE,  jmp_b: STEP_IDLE};
      STEP_CLEAR: w = '{ready: 1'b0, op: OP_CLEAR, seq: STEP_IDLE,
                        jmp_a: STEP_CLEAR, jmp_b: STEP_CLEAR};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/two_stage_page_walk_unit.sv
// ----------------------------------------------------------------------------
// Two-stage page walk unit
// Table memory loader and two-stage, two-level address translator with an
// APB-style register port for the two root pages.
// ----------------------------------------------------------------------------
// Items are taken one at a time when start is high and busy is low. A write
// item stores one 64-bit table word when word_index is inside the memory,
// and done is registered in the write step. A translation walks stage 1 and
// then stage 2, each with two dependent reads through the registered read
// port of the table memory: the root step issues the first-level read, the
// pointer step checks that entry and issues the leaf read, and the leaf step
// checks the leaf; the done step then registers the result. On a fault the
// fault step registers it instead, which is sooner unless the stage-2 leaf
// check faults. busy falls in the cycle in which done is high, so the next
// item can be taken at the edge that ends that cycle. The result is on
// status and the address ports for the one cycle in which done is high; the
// receiver cannot stall it, so it must capture the result then. After reset
// the table memory is cleared one word a cycle, so busy stays high until
// all MEM_PAGES * 512 words are cleared; register writes are taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module two_stage_page_walk_unit #(
  parameter int unsigned MEM_PAGES = tspw_pkg::MEM_PAGES_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Item channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            mode,
  input  wire logic [tspw_pkg::WIDX_BITS-1:0]  word_index,
  input  wire logic [tspw_pkg::ENTRY_BITS-1:0] write_data,
  input  wire logic [tspw_pkg::GVA_BITS-1:0]   guest_virtual_addr,
  // Result channel
  output logic                                 done,
  output tspw_pkg::status_t                    status,
  output logic      [tspw_pkg::ADDR_BITS-1:0]  guest_physical_addr,
  output logic      [tspw_pkg::ADDR_BITS-1:0]  host_physical_addr,
  // Register port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

  tspw_pkg::ctrl_t               ctrl;
  tspw_pkg::br_t                 br;
  logic [tspw_pkg::ROOT_BITS-1:0] stage1_root_page;
  logic [tspw_pkg::ROOT_BITS-1:0] stage2_root_page;
  logic                           reg_wr;

  // Register port: always ready, word address selects the register.
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_root_page <= '0;
      stage2_root_page <= '0;
    end else if (reg_wr) begin
      if (paddr[2] == tspw_pkg::REG_STAGE1_ROOT) begin
        stage1_root_page <= pwdata[tspw_pkg::ROOT_BITS-1:0];
      end else begin
        stage2_root_page <= pwdata[tspw_pkg::ROOT_BITS-1:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    if (paddr[2] == tspw_pkg::REG_STAGE1_ROOT) begin
      prdata = 32'(stage1_root_page);
    end else begin
      prdata = 32'(stage2_root_page);
    end
  end

  // The unit is ready only in the idle step of the microprogram.
  assign busy = !ctrl.ready;

  tspw_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .br   (br),
    .ctrl (ctrl)
  );

  tspw_dp #(
    .MEM_PAGES (MEM_PAGES)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .ctrl                (ctrl),
    .br                  (br),
    .start               (start),
    .mode                (mode),
    .word_index          (word_index),
    .write_data          (write_data),
    .guest_virtual_addr  (guest_virtual_addr),
    .stage1_root_page    (stage1_root_page),
    .stage2_root_page    (stage2_root_page),
    .done                (done),
    .status              (status),
    .guest_physical_addr (guest_physical_addr),
    .host_physical_addr  (host_physical_addr)
  );

endmodule

`default_nettype wire

### rtl/tspw_ram.sv
// ----------------------------------------------------------------------------
// Two-stage page walk: generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tspw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/tspw_seq.sv
// ----------------------------------------------------------------------------
// Two-stage page walk: microcode sequencer
// Step counter and microcode store with a three-way branch per step.
// ----------------------------------------------------------------------------
`default_nettype none

module tspw_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tspw_pkg::br_t   br,
  output tspw_pkg::ctrl_t      ctrl
);

  tspw_pkg::step_t upc;
  tspw_pkg::step_t upc_next;

  // The control word is read straight from the store at the current step.
  assign ctrl = tspw_pkg::ucode(upc);

  // Successor selection from the branch outcome.
  always_comb begin
    unique case (br)
      tspw_pkg::BR_A: upc_next = ctrl.jmp_a;
      tspw_pkg::BR_B: upc_next = ctrl.jmp_b;
      default:        upc_next = ctrl.seq;
    endcase
  end

  // After reset the program begins with the memory clearing loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= tspw_pkg::STEP_CLEAR;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

### rtl/tspw_dp.sv
// ----------------------------------------------------------------------------
// Two-stage page walk: datapath
// Table memory, walk registers, entry checks and result registers, all
// steered by the control word of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tspw_dp #(
  parameter int unsigned MEM_PAGES = tspw_pkg::MEM_PAGES_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tspw_pkg::ctrl_t                     ctrl,
  output tspw_pkg::br_t                            br,
  input  wire logic                                start,
  input  wire logic                                mode,
  input  wire logic [tspw_pkg::WIDX_BITS-1:0]      word_index,
  input  wire logic [tspw_pkg::ENTRY_BITS-1:0]     write_data,
  input  wire logic [tspw_pkg::GVA_BITS-1:0]       guest_virtual_addr,
  input  wire logic [tspw_pkg::ROOT_BITS-1:0]      stage1_root_page,
  input  wire logic [tspw_pkg::ROOT_BITS-1:0]      stage2_root_page,
  output logic                                     done,
  output tspw_pkg::status_t                        status,
  output logic      [tspw_pkg::ADDR_BITS-1:0]      guest_physical_addr,
  output logic      [tspw_pkg::ADDR_BITS-1:0]      host_physical_addr
);

  localparam int unsigned PW    = $clog2(MEM_PAGES);
  localparam int unsigned DEPTH = MEM_PAGES * 512;
  localparam int unsigned AW    = PW + tspw_pkg::IDX_BITS;

  // Walk registers.
  logic [tspw_pkg::WIDX_BITS-1:0]  wr_idx;
  logic [tspw_pkg::ENTRY_BITS-1:0] wr_data;
  logic [tspw_pkg::ADDR_BITS-1:0]  va;
  logic [tspw_pkg::ADDR_BITS-1:0]  gpa;
  logic [tspw_pkg::ADDR_BITS-1:0]  hpa;
  logic                            stage;
  logic [AW-1:0]                   clr_cnt;

  // Memory port signals.
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [tspw_pkg::ENTRY_BITS-1:0] ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [tspw_pkg::ENTRY_BITS-1:0] entry;

  // Decoded checks.
  logic [tspw_pkg::PPN_BITS-1:0]   root_page;
  logic [tspw_pkg::PPN_BITS-1:0]   ppn;
  logic                            root_ok;
  logic                            ptr_ok;
  logic                            leaf_ok;
  logic                            wr_in_range;
  logic                            clr_last;
  logic [tspw_pkg::ADDR_BITS-1:0]  leaf_addr;

  // The root of the stage under way, and the PPN of the entry just read.
  assign root_page = tspw_pkg::PPN_BITS'(stage ? stage2_root_page : stage1_root_page);
  assign ppn       = entry[tspw_pkg::PPN_LSB +: tspw_pkg::PPN_BITS];

  // A page at or past the end of the memory is a fault.
  assign root_ok = root_page < tspw_pkg::PPN_BITS'(MEM_PAGES);
  assign ptr_ok  = entry[tspw_pkg::FLAG_V] && (ppn < tspw_pkg::PPN_BITS'(MEM_PAGES));
  assign leaf_ok = entry[tspw_pkg::FLAG_V] &&
                   (entry[tspw_pkg::FLAG_R] || entry[tspw_pkg::FLAG_W] ||
                    entry[tspw_pkg::FLAG_X]);
  assign leaf_addr = {ppn, va[tspw_pkg::PAGE_SHIFT-1:0]};

  assign wr_in_range = 32'(wr_idx) < 32'(DEPTH);
  assign clr_last    = clr_cnt == AW'(DEPTH - 1);

  // Memory write: the clearing loop or a table write item.
  always_comb begin
    if (ctrl.op == tspw_pkg::OP_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = (ctrl.op == tspw_pkg::OP_WRITE) && wr_in_range;
      ram_waddr = AW'(wr_idx);
      ram_wdata = wr_data;
    end
  end

  // Memory read: first-level entry from the root page, or leaf from the
  // page named by the first-level entry.
  always_comb begin
    if (ctrl.op == tspw_pkg::OP_PTR) begin
      ram_raddr = {ppn[PW-1:0], va[20:12]};
    end else begin
      ram_raddr = {root_page[PW-1:0], va[29:21]};
    end
  end

  tspw_ram #(
    .WIDTH (tspw_pkg::ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (entry)
  );

  // Branch outcome for the sequencer.
  always_comb begin
    br = tspw_pkg::BR_SEQ;
    unique case (ctrl.op)
      tspw_pkg::OP_IDLE: begin
        if (start) begin
          br = mode ? tspw_pkg::BR_B : tspw_pkg::BR_A;
        end
      end
      tspw_pkg::OP_ROOT: begin
        if (!root_ok) begin
          br = tspw_pkg::BR_A;
        end
      end
      tspw_pkg::OP_PTR: begin
        if (!ptr_ok) begin
          br = tspw_pkg::BR_A;
        end
      end
      tspw_pkg::OP_LEAF: begin
        if (!leaf_ok) begin
          br = tspw_pkg::BR_A;
        end else if (!stage) begin
          br = tspw_pkg::BR_B;
        end
      end
      tspw_pkg::OP_CLEAR: begin
        if (!clr_last) begin
          br = tspw_pkg::BR_A;
        end
      end
      default: br = tspw_pkg::BR_SEQ;
    endcase
  end

  // Clearing counter and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      if (ctrl.op == tspw_pkg::OP_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      done <= (ctrl.op == tspw_pkg::OP_WRITE) || (ctrl.op == tspw_pkg::OP_DONE) ||
              (ctrl.op == tspw_pkg::OP_FAULT);
    end
  end

  // Item capture, stage hand-over and result payload.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      tspw_pkg::OP_IDLE: begin
        if (start) begin
          wr_idx  <= word_index;
          wr_data <= write_data;
          va      <= tspw_pkg::ADDR_BITS'(guest_virtual_addr);
          stage   <= 1'b0;
        end
      end
      tspw_pkg::OP_LEAF: begin
        if (leaf_ok) begin
          if (!stage) begin
            gpa   <= leaf_addr;
            va    <= leaf_addr;
            stage <= 1'b1;
          end else begin
            hpa <= leaf_addr;
          end
        end
      end
      tspw_pkg::OP_WRITE: begin
        status              <= tspw_pkg::ST_OK;
        guest_physical_addr <= '0;
        host_physical_addr  <= '0;
      end
      tspw_pkg::OP_DONE: begin
        status              <= tspw_pkg::ST_OK;
        guest_physical_addr <= gpa;
        host_physical_addr  <= hpa;
      end
      tspw_pkg::OP_FAULT: begin
        status              <= stage ? tspw_pkg::ST_S2_FAULT : tspw_pkg::ST_S1_FAULT;
        guest_physical_addr <= stage ? gpa : '0;
        host_physical_addr  <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
